[hw/rtl/crts_pkg.sv]
// Package for the clock rate table selector: codes, clock numbers, rate tables and bus types.
`default_nettype none
package crts_pkg;

	localparam int MDH_COUNT_DEF = 2;
	localparam int CORE_N = 9;
	localparam int MDH_N = 8;

	typedef enum logic [1:0] {
		CMD_GRANT_FREQ  = 2'd0,
		CMD_GRANT_RANGE = 2'd1,
		CMD_REPORT      = 2'd2,
		CMD_RESERVED    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_AT_LEAST = 2'd0,
		MODE_AT_MOST  = 2'd1,
		MODE_NEAREST  = 2'd2,
		MODE_UNSUPP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_NONE      = 3'd2,
		ST_NO_ABOVE  = 3'd3,
		ST_NO_BELOW  = 3'd4,
		ST_BAD_MODE  = 3'd5,
		ST_NOT_EXACT = 3'd6,
		ST_BAD_INDEX = 3'd7
	} status_t;

	localparam logic [6:0] CLK_CORE        = 7'd39;
	localparam logic [6:0] CLK_VSYNC       = 7'd43;
	localparam logic [6:0] CLK_PMDH        = 7'd115;
	localparam logic [6:0] CLK_PMDH_BRIDGE = 7'd116;
	localparam logic [6:0] CLK_MDP_BRIDGE  = 7'd42;
	localparam logic [6:0] CLK_AXI_MDP     = 7'd18;

	localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
	localparam logic [31:0] VSYNC_KHZ = 32'd24576;

	// All four tables are sorted in ascending order; the pick logic relies on it.
	localparam logic [31:0] CORE_HZ [CORE_N] = '{
		32'd24576000, 32'd46080000, 32'd49152000, 32'd52663000, 32'd92160000,
		32'd122880000, 32'd147456000, 32'd153600000, 32'd192000000};

	localparam logic [31:0] CORE_KHZ [CORE_N] = '{
		32'd24576, 32'd46080, 32'd49152, 32'd52663, 32'd92160,
		32'd122880, 32'd147456, 32'd153600, 32'd192000};

	localparam logic [31:0] MDH_HZ [MDH_N] = '{
		32'd49150000, 32'd92160000, 32'd122880000, 32'd184320000,
		32'd245760000, 32'd368640000, 32'd384000000, 32'd445500000};

	localparam logic [31:0] MDH_KHZ [MDH_N] = '{
		32'd49150, 32'd92160, 32'd122880, 32'd184320,
		32'd245760, 32'd368640, 32'd384000, 32'd445500};

	typedef struct packed {
		cmd_t        command;
		logic [6:0]  clock_id;
		logic [31:0] freq_hz;
		mode_t       match_mode;
		logic [2:0]  mdh_slot;
		logic [31:0] min_khz;
		logic [31:0] max_khz;
	} req_t;

	typedef struct packed {
		logic [31:0] rate;
		status_t     status;
	} rsp_t;

	// Granted rates are kept as table indexes; a clear valid bit means not granted.
	typedef struct packed {
		logic       core_valid;
		logic [3:0] core_idx;
		logic       mdh0_valid;
		logic [2:0] mdh0_idx;
	} view_t;

	typedef struct packed {
		logic       core_we;
		logic [3:0] core_idx;
		logic       mdh_we;
		logic [2:0] mdh_slot;
		logic       mdh_valid;
		logic [2:0] mdh_idx;
	} upd_t;

endpackage
`default_nettype wire

[hw/rtl/crts_req_stage.sv]
// Input register stage of the clock rate table selector.
`default_nettype none
module crts_req_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	output logic               ready,
	input  wire crts_pkg::req_t req,
	input  wire logic          advance,
	output logic               valid_s1,
	output crts_pkg::req_t     req_s1
);

	assign ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			req_s1 <= req;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/crts_grant_logic.sv]
// Combinational grant, range and report decode for one registered transaction.
`default_nettype none
module crts_grant_logic #(
	parameter int MDH_COUNT = crts_pkg::MDH_COUNT_DEF
) (
	input  wire crts_pkg::req_t  req,
	input  wire crts_pkg::view_t view,
	output crts_pkg::rsp_t       rsp,
	output crts_pkg::upd_t       upd
);

	localparam logic [3:0] SLOT_LIMIT = 4'(MDH_COUNT);

	logic [crts_pkg::CORE_N-1:0] core_eq;
	logic [3:0]                  core_hit_idx;
	logic [crts_pkg::MDH_N-1:0]  mdh_eq, mdh_gt, mdh_lt, in_range;
	logic [2:0]                  eq_idx, above_idx, below_idx, range_idx, pick_idx;
	logic [31:0]                 above_hz, below_hz;
	logic                        nearest_up;
	crts_pkg::status_t           pick_st;

	always_comb begin
		core_hit_idx = '0;
		for (int i = 0; i < crts_pkg::CORE_N; i++) begin
			core_eq[i] = (crts_pkg::CORE_HZ[i] == req.freq_hz);
			if (core_eq[i]) core_hit_idx = 4'(i);
		end
		eq_idx = '0;
		below_idx = '0;
		range_idx = '0;
		for (int i = 0; i < crts_pkg::MDH_N; i++) begin
			mdh_eq[i] = (crts_pkg::MDH_HZ[i] == req.freq_hz);
			mdh_gt[i] = (crts_pkg::MDH_HZ[i] > req.freq_hz);
			mdh_lt[i] = (crts_pkg::MDH_HZ[i] < req.freq_hz);
			in_range[i] = (crts_pkg::MDH_KHZ[i] >= req.min_khz) &&
			              (crts_pkg::MDH_KHZ[i] <= req.max_khz);
			if (mdh_eq[i]) eq_idx = 3'(i);
			if (mdh_lt[i]) below_idx = 3'(i);
			if (in_range[i]) range_idx = 3'(i);
		end
		// The lowest entry above the request is the first one set.
		above_idx = '0;
		for (int i = crts_pkg::MDH_N - 1; i >= 0; i--) begin
			if (mdh_gt[i]) above_idx = 3'(i);
		end
	end

	assign above_hz = crts_pkg::MDH_HZ[above_idx];
	assign below_hz = crts_pkg::MDH_HZ[below_idx];
	// Ties go to the higher rate.
	assign nearest_up = (req.freq_hz - below_hz) >= (above_hz - req.freq_hz);

	always_comb begin
		pick_idx = below_idx;
		pick_st = (|mdh_lt) ? crts_pkg::ST_OK : crts_pkg::ST_NO_BELOW;
		if (|mdh_eq) begin
			pick_idx = eq_idx;
			pick_st = crts_pkg::ST_OK;
		end else begin
			unique case (req.match_mode)
				crts_pkg::MODE_NEAREST: begin
					if ((|mdh_gt) && (!(|mdh_lt) || nearest_up)) begin
						pick_idx = above_idx;
						pick_st = crts_pkg::ST_OK;
					end
				end
				crts_pkg::MODE_AT_LEAST: begin
					// An all-ones request falls back to the next lower rate.
					if (req.freq_hz != crts_pkg::ALL_ONES) begin
						pick_idx = above_idx;
						pick_st = (|mdh_gt) ? crts_pkg::ST_OK : crts_pkg::ST_NO_ABOVE;
					end
				end
				crts_pkg::MODE_AT_MOST: begin
				end
				default: begin
					pick_st = crts_pkg::ST_BAD_MODE;
				end
			endcase
		end
	end

	always_comb begin
		rsp.rate = '0;
		rsp.status = crts_pkg::ST_OK;
		upd = '0;
		upd.mdh_slot = req.mdh_slot;
		unique case (req.command)
			crts_pkg::CMD_GRANT_FREQ: begin
				if (req.clock_id == crts_pkg::CLK_CORE) begin
					if (|core_eq) begin
						rsp.rate = req.freq_hz;
						upd.core_we = 1'b1;
						upd.core_idx = core_hit_idx;
					end else begin
						rsp.status = crts_pkg::ST_NOT_EXACT;
					end
				end else if (req.clock_id == crts_pkg::CLK_PMDH) begin
					rsp.status = pick_st;
					if (pick_st == crts_pkg::ST_OK) begin
						rsp.rate = crts_pkg::MDH_HZ[pick_idx];
						upd.mdh_we = 1'b1;
						upd.mdh_slot = '0;
						upd.mdh_valid = 1'b1;
						upd.mdh_idx = pick_idx;
					end
				end else begin
					rsp.status = crts_pkg::ST_UNKNOWN;
				end
			end
			crts_pkg::CMD_GRANT_RANGE: begin
				if ({1'b0, req.mdh_slot} >= SLOT_LIMIT) begin
					rsp.status = crts_pkg::ST_BAD_INDEX;
				end else begin
					// An empty range still stores zero, which clears the grant.
					upd.mdh_we = 1'b1;
					upd.mdh_valid = |in_range;
					upd.mdh_idx = range_idx;
					if (|in_range) rsp.rate = crts_pkg::MDH_KHZ[range_idx];
				end
			end
			crts_pkg::CMD_REPORT: begin
				if (req.clock_id == crts_pkg::CLK_CORE) begin
					if (view.core_valid) rsp.rate = crts_pkg::CORE_KHZ[view.core_idx];
					else rsp.status = crts_pkg::ST_NONE;
				end else if (req.clock_id == crts_pkg::CLK_VSYNC) begin
					rsp.rate = crts_pkg::VSYNC_KHZ;
				end else if (req.clock_id == crts_pkg::CLK_PMDH) begin
					if (view.mdh0_valid) rsp.rate = crts_pkg::MDH_KHZ[view.mdh0_idx];
					else rsp.status = crts_pkg::ST_NONE;
				end else if (req.clock_id == crts_pkg::CLK_PMDH_BRIDGE ||
				             req.clock_id == crts_pkg::CLK_MDP_BRIDGE ||
				             req.clock_id == crts_pkg::CLK_AXI_MDP) begin
					rsp.rate = '0;
				end else begin
					rsp.status = crts_pkg::ST_UNKNOWN;
				end
			end
			default: begin
				rsp.status = crts_pkg::ST_BAD_MODE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/crts_rsp_stage.sv]
// Result register stage of the clock rate table selector.
`default_nettype none
module crts_rsp_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire crts_pkg::rsp_t rsp,
	output logic                advance,
	output logic                valid,
	input  wire logic           ready,
	output crts_pkg::rsp_t      rsp_s2
);

	assign advance = !valid || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (advance) begin
			valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= rsp;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/clock_rate_table_selector.sv]
// Top level of the clock rate table selector: stages, grant state and ports.
//
// Request channel (req_valid/req_ready) carries one command per transaction:
// grant by frequency, grant an mdh slot by kHz range, or report a clock's kHz.
// Response channel (rsp_valid/rsp_ready) returns one rate and status for
// every request, in order.
// A transaction passes one input register, the table compare and decode
// logic, then the result register. Throughput is one transaction per cycle
// unless the receiver stalls; the rate tables are constants, so all entries
// are compared in parallel in the compare and decode logic.
// Grant state is written when a result enters the result register, so the
// next request sees it without any bubble.
// When the receiver stalls, the result register holds its transaction, the
// input register fills with one more, and req_ready then drops until
// rsp_ready returns.
// Reset clears both stage valids and marks every clock as not granted.
`default_nettype none
module clock_rate_table_selector #(
	parameter int MDH_COUNT = crts_pkg::MDH_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  command,
	input  wire logic [6:0]  clock_id,
	input  wire logic [31:0] freq_hz,
	input  wire logic [1:0]  match_mode,
	input  wire logic [2:0]  mdh_slot,
	input  wire logic [31:0] min_khz,
	input  wire logic [31:0] max_khz,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [31:0]      rate,
	output logic [2:0]       status
);

	crts_pkg::req_t  req_in, req_s1;
	crts_pkg::rsp_t  rsp_c, rsp_s2;
	crts_pkg::view_t view;
	crts_pkg::upd_t  upd;
	logic            valid_s1, advance;

	logic       core_valid_q;
	logic [3:0] core_idx_q;
	logic       mdh_valid_q [MDH_COUNT];
	logic [2:0] mdh_idx_q [MDH_COUNT];

	assign req_in.command    = crts_pkg::cmd_t'(command);
	assign req_in.clock_id   = clock_id;
	assign req_in.freq_hz    = freq_hz;
	assign req_in.match_mode = crts_pkg::mode_t'(match_mode);
	assign req_in.mdh_slot   = mdh_slot;
	assign req_in.min_khz    = min_khz;
	assign req_in.max_khz    = max_khz;

	crts_req_stage u_req (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (req_valid),
		.ready    (req_ready),
		.req      (req_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	assign view.core_valid = core_valid_q;
	assign view.core_idx   = core_idx_q;
	assign view.mdh0_valid = mdh_valid_q[0];
	assign view.mdh0_idx   = mdh_idx_q[0];

	crts_grant_logic #(
		.MDH_COUNT (MDH_COUNT)
	) u_grant (
		.req  (req_s1),
		.view (view),
		.rsp  (rsp_c),
		.upd  (upd)
	);

	crts_rsp_stage u_rsp (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.rsp      (rsp_c),
		.advance  (advance),
		.valid    (rsp_valid),
		.ready    (rsp_ready),
		.rsp_s2   (rsp_s2)
	);

	assign rate   = rsp_s2.rate;
	assign status = rsp_s2.status;

	// State moves together with the transaction into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_valid_q <= 1'b0;
			core_idx_q <= '0;
			for (int i = 0; i < MDH_COUNT; i++) begin
				mdh_valid_q[i] <= 1'b0;
				mdh_idx_q[i] <= '0;
			end
		end else if (advance && valid_s1) begin
			if (upd.core_we) begin
				core_valid_q <= 1'b1;
				core_idx_q <= upd.core_idx;
			end
			for (int i = 0; i < MDH_COUNT; i++) begin
				if (upd.mdh_we && upd.mdh_slot == 3'(i)) begin
					mdh_valid_q[i] <= upd.mdh_valid;
					mdh_idx_q[i] <= upd.mdh_idx;
				end
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/crts_checker.sv]
// Port-level checker for the clock rate table selector, bound to the top level.
`default_nettype none
module crts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rate,
	input wire logic [2:0]  status
);

	// A stalled response keeps its transaction.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rate) && $stable(status))
		else $error("response changed while stalled");

	// Every failure reports a zero rate.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != crts_pkg::ST_OK |-> rate == 32'd0)
		else $error("failing response carries a nonzero rate");

	// The request side only blocks when both stages are full and stalled.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request blocked without a stalled response");

	// A response that appears on an empty output came through both stage registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response appeared without a matching request");

endmodule

bind clock_rate_table_selector crts_checker u_crts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rate      (rate),
	.status    (status)
);
`default_nettype wire
